// ----- hdl/chained_block_dma_channels_defines.svh -----
// ---------------------------------------------------------------------------
// Chained block DMA channels: assertion macros
// Shared property macros for the sequencer checks. They are empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef CHAINED_BLOCK_DMA_CHANNELS_DEFINES_SVH
`define CHAINED_BLOCK_DMA_CHANNELS_DEFINES_SVH

`ifndef SYNTHESIS
`define CBDMA_ASSERT_IMP(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("cbdma check failed");
`define CBDMA_ASSERT_NXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("cbdma check failed");
`else
`define CBDMA_ASSERT_IMP(label, clk, rst_n, cond, expr)
`define CBDMA_ASSERT_NXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ----- hdl/cbdma_pkg.sv -----
// ---------------------------------------------------------------------------
// Chained block DMA channels: package
// Request and result types, action and status codes, and shared constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbdma_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam logic [7:0] MAX_EVENT_RST = 8'd15;

    typedef enum logic [2:0] {
        ACT_REGISTER   = 3'd0,
        ACT_UNREGISTER = 3'd1,
        ACT_TX_START   = 3'd2,
        ACT_RX_START   = 3'd3,
        ACT_EVENT      = 3'd4,
        ACT_POLL_TX    = 3'd5,
        ACT_POLL_RX    = 3'd6,
        ACT_NOP        = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CHANNEL = 2'd1,
        ST_PENDING     = 2'd2
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [3:0]  channel;
        logic [31:0] buffer_address;
        logic [31:0] blk_bytes;
        logic [15:0] blk_total;
        logic [7:0]  event_code;
        logic        rx_pending;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic        program_valid;
        logic        program_is_tx;
        logic [2:0]  program_channel;
        logic [31:0] program_address;
        logic [31:0] program_size;
        logic        done_valid;
        logic        done_is_tx;
        logic [2:0]  done_channel;
        logic [7:0]  clock_gates;
    } t_out_item;

    // One side of one channel in the transfer table.
    typedef struct packed {
        logic [31:0] address;
        logic [31:0] size;
        logic [15:0] count;
    } t_entry;

endpackage

`default_nettype wire

// ----- hdl/cbdma_chan_table.sv -----
// ---------------------------------------------------------------------------
// Chained block DMA channels: transfer table
// Synchronous memory of address, size and block count per channel side,
// with per-entry valid bits so that an unwritten count reads as zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbdma_chan_table
    import cbdma_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    localparam int DEPTH = 2 * CHANNELS,
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int IDX_W = CH_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_entry           o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_entry           i_wr_data
);

    t_entry             r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    t_entry             r_rd_entry;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    // Address and size of an unwritten entry are never used; only the count matters.
    always_comb begin
        o_rd_data       = r_rd_entry;
        o_rd_data.count = r_rd_valid ? r_rd_entry.count : 16'd0;
    end

endmodule

`default_nettype wire

// ----- hdl/cbdma_engine.sv -----
// ---------------------------------------------------------------------------
// Chained block DMA channels: request engine
// Reads the addressed table entry, decides the action, writes the entry
// back and registers the result. Also holds the channel registration bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbdma_engine
    import cbdma_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int IDX_W = CH_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic [7:0]       i_max_event,
    output logic             o_tbl_rd_en,
    output logic [IDX_W-1:0] o_tbl_rd_idx,
    input  t_entry           i_tbl_rd_data,
    output logic             o_tbl_wr_en,
    output logic [IDX_W-1:0] o_tbl_wr_idx,
    output t_entry           o_tbl_wr_data
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

    t_state              r_state;
    t_in_item            r_item;
    logic [IDX_W-1:0]    r_idx;
    logic                r_dir;
    logic [CHANNELS-1:0] r_registered;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                in_acc;
    logic                rd_dir;
    logic [CH_W-1:0]     rd_ch;
    logic                ch_bad;
    logic [CH_W-1:0]     ch_idx;
    logic [6:0]          ev_ch;
    logic                ev_taken;
    logic                wr_req;
    logic [CHANNELS-1:0] n_registered;
    logic [15:0]         gate_pad;
    t_out_item           n_out;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Table address of the request: channel in the upper bits, direction at the bottom.
    always_comb begin
        if (i_in_data.action == ACT_EVENT) begin
            rd_dir = i_in_data.event_code[0];
            rd_ch  = i_in_data.event_code[CH_W:1];
        end else begin
            rd_dir = (i_in_data.action == ACT_TX_START) || (i_in_data.action == ACT_POLL_TX);
            rd_ch  = i_in_data.channel[CH_W-1:0];
        end
    end

    assign o_tbl_rd_en  = in_acc;
    assign o_tbl_rd_idx = {rd_ch, rd_dir};

    assign ch_bad = {1'b0, r_item.channel} >= CH_LIMIT;
    assign ch_idx = r_item.channel[CH_W-1:0];
    assign ev_ch  = r_item.event_code[7:1];
    assign ev_taken = (r_item.event_code <= i_max_event) && ({1'b0, ev_ch} < 8'(CHANNELS))
                      && r_registered[ev_ch[CH_W-1:0]];

    always_comb begin
        n_registered  = r_registered;
        wr_req        = 1'b0;
        o_tbl_wr_data = i_tbl_rd_data;
        n_out         = '0;
        n_out.status  = ST_OK;
        unique case (r_item.action) inside
            ACT_REGISTER, ACT_UNREGISTER: begin
                if (ch_bad) begin
                    n_out.status = ST_BAD_CHANNEL;
                end else begin
                    n_registered[ch_idx] = (r_item.action == ACT_REGISTER);
                end
            end
            ACT_TX_START, ACT_RX_START: begin
                if (ch_bad) begin
                    n_out.status = ST_BAD_CHANNEL;
                end else begin
                    wr_req                = 1'b1;
                    o_tbl_wr_data.address = r_item.buffer_address;
                    o_tbl_wr_data.size    = r_item.blk_bytes;
                    o_tbl_wr_data.count   = r_item.blk_total;
                    n_out.program_valid   = 1'b1;
                    n_out.program_is_tx   = r_dir;
                    n_out.program_channel = r_item.channel[2:0];
                    n_out.program_address = r_item.buffer_address;
                    n_out.program_size    = r_item.blk_bytes;
                end
            end
            ACT_POLL_TX, ACT_POLL_RX: begin
                if (ch_bad) begin
                    n_out.status = ST_BAD_CHANNEL;
                end else if (i_tbl_rd_data.count != 16'd0) begin
                    n_out.status = ST_PENDING;
                end
            end
            ACT_EVENT: begin
                if (ev_taken) begin
                    if (i_tbl_rd_data.count > 16'd1) begin
                        // Chain the next block: one fewer left, address moves by the size.
                        wr_req                = 1'b1;
                        o_tbl_wr_data.count   = i_tbl_rd_data.count - 16'd1;
                        o_tbl_wr_data.address = i_tbl_rd_data.address + i_tbl_rd_data.size;
                        n_out.program_valid   = 1'b1;
                        n_out.program_is_tx   = r_dir;
                        n_out.program_channel = ev_ch[2:0];
                        n_out.program_address = o_tbl_wr_data.address;
                        n_out.program_size    = i_tbl_rd_data.size;
                    end else if (r_dir || !r_item.rx_pending) begin
                        wr_req              = 1'b1;
                        o_tbl_wr_data.count = 16'd0;
                        n_out.done_valid    = 1'b1;
                        n_out.done_is_tx    = r_dir;
                        n_out.done_channel  = ev_ch[2:0];
                    end
                end
            end
            ACT_NOP: begin
            end
        endcase
        gate_pad          = 16'(n_registered);
        n_out.clock_gates = gate_pad[7:0];
    end

    assign o_tbl_wr_en  = (r_state == S_EXEC) && wr_req;
    assign o_tbl_wr_idx = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_registered <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item  <= i_in_data;
                        r_idx   <= o_tbl_rd_idx;
                        r_dir   <= rd_dir;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_out        <= n_out;
                    r_out_valid  <= 1'b1;
                    r_registered <= n_registered;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- hdl/chained_block_dma_channels.sv -----
// Block-chaining DMA sequencer for up to CHANNELS channels, each with a transmit and
// a receive side. Every request gives exactly one result. The channel table is a
// synchronous memory, read in the cycle the request is accepted and written back in
// the next, so no new request is taken while one is in flight. The result sits in an
// output register, and a new request is taken only at an edge where no result waits
// or the waiting result leaves at that edge. Counts of never-started channels read as
// zero through per-entry valid bits cleared by reset, so there is no clearing pass
// after reset. max_event is written on its own port, which is always ready; the user
// must write it only while no request is in flight, as the block does not enforce it.
// ---------------------------------------------------------------------------
// Chained block DMA channels: top level
// Configuration register, transfer table and request engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "chained_block_dma_channels_defines.svh"

module chained_block_dma_channels
    import cbdma_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W = CH_W + 1;

    logic [7:0]       r_max_event;
    logic             tbl_rd_en;
    logic [IDX_W-1:0] tbl_rd_idx;
    t_entry           tbl_rd_data;
    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_wr_idx;
    t_entry           tbl_wr_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_event <= MAX_EVENT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_event <= i_cfg_data;
        end
    end

    cbdma_chan_table #(
        .CHANNELS (CHANNELS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (tbl_rd_en),
        .i_rd_idx  (tbl_rd_idx),
        .o_rd_data (tbl_rd_data),
        .i_wr_en   (tbl_wr_en),
        .i_wr_idx  (tbl_wr_idx),
        .i_wr_data (tbl_wr_data)
    );

    cbdma_engine #(
        .CHANNELS (CHANNELS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .i_max_event   (r_max_event),
        .o_tbl_rd_en   (tbl_rd_en),
        .o_tbl_rd_idx  (tbl_rd_idx),
        .i_tbl_rd_data (tbl_rd_data),
        .o_tbl_wr_en   (tbl_wr_en),
        .o_tbl_wr_idx  (tbl_wr_idx),
        .o_tbl_wr_data (tbl_wr_data)
    );

    // The table read of one request and its write-back never overlap with the next.
    `CBDMA_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `CBDMA_ASSERT_IMP(a_prog_done_excl, i_clk, i_rst_n, o_out_valid, !(o_out_data.program_valid && o_out_data.done_valid))
    `CBDMA_ASSERT_IMP(a_prog_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.program_valid, (o_out_data.program_address == 32'd0) && (o_out_data.program_size == 32'd0))
    `CBDMA_ASSERT_IMP(a_status_ok, i_clk, i_rst_n, o_out_valid && (o_out_data.program_valid || o_out_data.done_valid), o_out_data.status == ST_OK)

endmodule

`default_nettype wire
